FILE: rtl/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
// No dependencies; used by swm_cell and sliding_window_median_top.
`default_nettype none

package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  // Counts cover the full parameter range (up to 1024 cells).
  localparam int CNT_W          = 11;
  localparam int AGE_W          = 10;
  localparam int MAX_WINDOW_DEF = 64;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(3);

  // Old entry handed from a cell to its left neighbor.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [AGE_W-1:0]  age;
  } swm_entry_t;

  // Compacted entry and flags handed from a cell to its right neighbor.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [AGE_W-1:0]  age;
    logic              gt;
    logic              rl;
  } swm_link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic              en;
    logic              full;
    logic [DATA_W-1:0] sample;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  wm1;
    logic [CNT_W-1:0]  med_idx;
  } swm_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One cell of the sorted window: holds a value and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median_top.
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int IDX = 0,
  parameter int AW  = 6
) (
  input  wire logic       clk,
  input  wire swm_ctl_t   ctl,
  input  wire swm_link_t  left_in,
  input  wire swm_entry_t right_in,
  output swm_link_t       right_out,
  output swm_entry_t      left_out,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] val;
  logic [AW-1:0]     age;

  logic              rm;
  logic              rl;
  logic              cvalid;
  logic              cgt;
  logic [DATA_W-1:0] c_val;
  logic [AGE_W-1:0]  c_age;
  logic [DATA_W-1:0] val_next;
  logic [AW-1:0]     age_next;

  always_comb begin
    // The oldest sample of a full window leaves from this cell.
    rm     = ctl.full && (CNT_W'(IDX) <= ctl.wm1) && (CNT_W'(age) == ctl.wm1);
    rl     = left_in.rl || rm;
    // Close the gap: take the right neighbor once the removal is at or left of here.
    c_val  = rl ? right_in.val : val;
    c_age  = rl ? right_in.age : AGE_W'(age);
    cvalid = CNT_W'(IDX) < ctl.cnt;
    cgt    = cvalid && (c_val > ctl.sample);
    if (left_in.gt) begin
      val_next = left_in.val;
      age_next = AW'(left_in.age + AGE_W'(1));
    end else if (cgt || !cvalid) begin
      val_next = ctl.sample;
      age_next = '0;
    end else begin
      val_next = c_val;
      age_next = AW'(c_age + AGE_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val <= val_next;
      age <= age_next;
    end
  end

  assign right_out = '{val: c_val, age: c_age, gt: cgt, rl: rl};
  assign left_out  = '{val: val, age: AGE_W'(age)};
  assign tap       = (CNT_W'(IDX) == ctl.med_idx) ? val : '0;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median_top.sv
// Sliding-window lower-median filter: a row of sorted cells with age tags.
// Depends on swm_pkg and swm_cell.
// Throughput: one sample per clock; the whole row of cells updates together.
//   The input stalls only while a finished result waits behind a stalled output.
// Output path: an accepted sample's result is first held pending, then moves into the
//   output register (m_tvalid) as soon as that register is free.
// Reset: empties the window and sets window size to 3; cell contents are not cleared.
`default_nettype none

module sliding_window_median_top import swm_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration: window_size
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // s_tdata: [31:0] sample
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,
  input  wire logic              s_tlast,
  // m_tdata: [31:0] median
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,
  output logic                   m_tlast
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CFG_W-1:0] window_size;
  logic [CNT_W-1:0] fill_count;
  logic             pend;
  logic             pend_last;

  logic [CNT_W-1:0] ws_ext;
  logic [CNT_W-1:0] max_c;
  logic [CNT_W-1:0] eff_size;
  logic             full;
  logic             produced;
  logic             accept;
  logic             out_free;
  logic [DATA_W-1:0] median_or;
  swm_ctl_t         ctl;

  swm_link_t  link [MAX_WINDOW+1];
  swm_entry_t back [MAX_WINDOW+1];
  logic [DATA_W-1:0] taps [MAX_WINDOW];

  // Clamp the window size into 1..MAX_WINDOW.
  always_comb begin
    ws_ext = CNT_W'(window_size);
    max_c  = CNT_W'(MAX_WINDOW);
    if (window_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (ws_ext > max_c) begin
      eff_size = max_c;
    end else begin
      eff_size = ws_ext;
    end
  end

  assign full      = fill_count >= eff_size;
  // A result comes once the window is full after this sample goes in.
  assign produced  = full || ((fill_count + CNT_W'(1)) == eff_size);
  assign out_free  = !m_tvalid || m_tready;
  // Take a new sample unless a finished result still waits behind a stalled output.
  assign s_tready  = !pend || out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ctl.en      = accept;
    ctl.full    = full;
    ctl.sample  = s_tdata;
    // Entries left after the oldest one drops out of a full window; else the fill count.
    ctl.cnt     = full ? (eff_size - CNT_W'(1)) : fill_count;
    ctl.wm1     = eff_size - CNT_W'(1);
    ctl.med_idx = (eff_size - CNT_W'(1)) >> 1;
  end

  assign link[0]          = '0;
  assign back[MAX_WINDOW] = '0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_in   (link[i]),
      .right_in  (back[i+1]),
      .right_out (link[i+1]),
      .left_out  (back[i]),
      .tap       (taps[i])
    );
  end

  // Only the median cell drives a nonzero tap.
  always_comb begin
    median_or = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      median_or = median_or | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      fill_count  <= '0;
      pend        <= 1'b0;
      pend_last   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // Any register write empties the window.
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
        fill_count  <= '0;
      end else if (accept) begin
        if (s_tlast) begin
          fill_count <= '0;
        end else if (!full) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end

      // Advance a pending result into the output register.
      if (pend && out_free) begin
        m_tvalid <= 1'b1;
        m_tlast  <= pend_last;
        m_tdata  <= median_or;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        pend      <= produced;
        pend_last <= s_tlast;
      end else if (out_free) begin
        pend <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= eff_size)
    else $error("fill count exceeds window size");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (pend && m_tvalid && !m_tready))
    else $error("input stalled without a waiting result");

  a_result_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && produced) |=> pend)
    else $error("result of accepted sample not pending");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (fill_count == '0))
    else $error("window not emptied after last sample");

endmodule

`default_nettype wire
